@@ rtl/mpq_pkg.sv @@
// Shared types and constants for the minimum priority queue.
// Entry layout, per-cell control bundle, operation and status codes.
// No dependencies.
package mpq_pkg;

  localparam int DEFAULT_CAPACITY = 16;

  localparam int VALUE_W = 32;
  localparam int PRIO_W  = 16;
  localparam int IN_W    = 56;

  typedef enum logic {
    OP_INSERT  = 1'b0,
    OP_EXTRACT = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic signed [PRIO_W-1:0]  prio;
  } entry_t;

  // Broadcast to every cell in the chain each cycle
  typedef struct packed {
    logic   ins;
    logic   ext;
    entry_t new_entry;
  } cell_ctrl_t;

endpackage

@@ rtl/mpq_cell.sv @@
// One cell of the sorted queue chain: holds a single entry.
// Shifts left on extract, takes the new entry or its left neighbour on insert.
// Depends on mpq_pkg.
module mpq_cell
  import mpq_pkg::*;
(
  input  logic       clk,
  input  cell_ctrl_t ctrl,
  input  logic       occupied,
  input  logic       left_le,
  input  entry_t     left_entry,
  input  entry_t     right_entry,
  output entry_t     entry,
  output logic       le
);

  entry_t entry_next;

  // Equal priorities stay ahead of the newcomer, which keeps arrival order
  assign le = occupied && ($signed(entry.prio) <= $signed(ctrl.new_entry.prio));

  always_comb begin
    entry_next = entry;
    if (ctrl.ext) begin
      entry_next = right_entry;
    end else if (ctrl.ins && !le) begin
      if (left_le) begin
        entry_next = ctrl.new_entry;
      end else begin
        entry_next = left_entry;
      end
    end
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

endmodule

@@ rtl/min_priority_queue.sv @@
// Minimum priority queue built as a chain of sorted compare cells.
// Input item on s_tvalid/s_tready/s_tdata, one result per item on
// m_tvalid/m_tready/m_tdata.
// An insert transfer places a (value, priority) pair into the chain behind
// every stored pair of smaller or equal priority; an extract transfer
// returns the head of the chain, which is the earliest inserted pair of
// the smallest priority, and every cell shifts one place towards the head.
// Each cell compares its own priority against the broadcast newcomer, so
// an item completes whatever the fill level: one item per cycle is taken
// while s_tready is high, and its result is registered and appears on
// m_tdata in the cycle after the input transfer.
// Results wait in a single output register. While it is full and m_tready
// is low, s_tready is low and the queue holds; a new item is taken in the
// same cycle as the waiting result is transferred.
// An insert on a full queue is dropped with status 1; an extract on an
// empty queue gives status 2 and zero value and priority.
// Synchronous reset empties the queue and the output register; no
// clearing pass is needed, cell contents are only read below the count.
module min_priority_queue
  import mpq_pkg::*;
#(
  parameter int CAPACITY = DEFAULT_CAPACITY
) (
  input  logic clk,
  input  logic rst,

  input  logic            s_tvalid,
  output logic            s_tready,
  // [0] op, [32:1] in_value, [48:33] in_priority, rest zero
  input  logic [IN_W-1:0] s_tdata,

  output logic                                   m_tvalid,
  input  logic                                   m_tready,
  // [31:0] out_value, [47:32] out_priority, [48] got_entry,
  // [50:49] status, then entry_count, rest zero
  output logic [((VALUE_W+PRIO_W+3+$clog2(CAPACITY+1)+7)/8)*8-1:0] m_tdata
);

  localparam int COUNT_W  = $clog2(CAPACITY + 1);
  localparam int OUT_BITS = VALUE_W + PRIO_W + 3 + COUNT_W;
  localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

  logic               accept;
  op_t                in_op;
  logic               full;
  logic               empty;
  cell_ctrl_t         ctrl;
  logic [COUNT_W-1:0] count;
  logic [COUNT_W-1:0] count_next;

  entry_t               cells     [CAPACITY];
  logic [CAPACITY-1:0]  le;
  logic [CAPACITY-1:0]  occupied;

  logic                      out_got;
  status_t                   out_status;
  logic [COUNT_W-1:0]        out_count;
  logic signed [VALUE_W-1:0] out_value;
  logic signed [PRIO_W-1:0]  out_prio;

  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;
  assign in_op    = op_t'(s_tdata[0]);

  assign full  = (count == COUNT_W'(CAPACITY));
  assign empty = (count == '0);

  always_comb begin
    ctrl.ins             = accept && (in_op == OP_INSERT) && !full;
    ctrl.ext             = accept && (in_op == OP_EXTRACT) && !empty;
    ctrl.new_entry.value = s_tdata[VALUE_W:1];
    ctrl.new_entry.prio  = s_tdata[VALUE_W+PRIO_W:VALUE_W+1];
  end

  always_comb begin
    count_next = count;
    if (ctrl.ins) begin
      count_next = count + 1'b1;
    end else if (ctrl.ext) begin
      count_next = count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    assign occupied[i] = (COUNT_W'(i) < count);

    mpq_cell u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .occupied    (occupied[i]),
      .left_le     ((i == 0) ? 1'b1 : le[(i == 0) ? 0 : i - 1]),
      .left_entry  (cells[(i == 0) ? 0 : i - 1]),
      .right_entry ((i == CAPACITY - 1) ? cells[i] : cells[(i == CAPACITY - 1) ? i : i + 1]),
      .entry       (cells[i]),
      .le          (le[i])
    );
  end

  // Output register: hold until transferred
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_count <= count_next;
      out_got   <= ctrl.ext;
      out_value <= ctrl.ext ? cells[0].value : '0;
      out_prio  <= ctrl.ext ? cells[0].prio : '0;
      if (in_op == OP_INSERT && full) begin
        out_status <= STATUS_FULL;
      end else if (in_op == OP_EXTRACT && empty) begin
        out_status <= STATUS_EMPTY;
      end else begin
        out_status <= STATUS_OK;
      end
    end
  end

  assign m_tdata = OUT_W'({out_count, out_status, out_got, out_prio, out_value});

  a_count_bound : assert property (@(posedge clk) disable iff (rst)
    count <= COUNT_W'(CAPACITY))
    else $error("entry count beyond capacity");

  a_insert_grows : assert property (@(posedge clk) disable iff (rst)
    ctrl.ins |=> count == $past(count) + 1'b1)
    else $error("insert did not grow the queue");

  a_extract_result : assert property (@(posedge clk) disable iff (rst)
    ctrl.ext |=> m_tvalid && out_got && out_status == STATUS_OK)
    else $error("extract result missing its entry");

  a_head_sorted : assert property (@(posedge clk) disable iff (rst)
    count >= COUNT_W'(2) |-> $signed(cells[0].prio) <= $signed(cells[1].prio))
    else $error("queue head out of order");

endmodule
